// ----- hw/rtl/ppp_pkg.sv -----
package ppp_pkg;

    localparam int OUT_BITS  = 24;
    localparam int PIX_FRAC  = 6;
    localparam int ROT_FRAC  = 19;
    localparam int HOMO_SH   = 8;
    localparam int REG_BITS  = 63;
    localparam int IDX_BITS  = 3;
    localparam int NUM_REGS  = 7;
    localparam int ACC_BITS  = 64;

    localparam logic [IDX_BITS-1:0] REG_ROT0  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_ROT1  = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_ROT2  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_TRANS = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_INTR0 = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_INTR1 = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_INTR2 = 3'd6;

    // Saturate a signed 64-bit value to the output range.
    function automatic logic [OUT_BITS:0] sat64(input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        begin
            hi = ACC_BITS'(2 ** (OUT_BITS - 1) - 1);
            lo = -ACC_BITS'(2 ** (OUT_BITS - 1));
            if (v > hi)
                sat64 = {1'b1, hi[OUT_BITS-1:0]};
            else if (v < lo)
                sat64 = {1'b1, lo[OUT_BITS-1:0]};
            else
                sat64 = {1'b0, v[OUT_BITS-1:0]};
        end
    endfunction

    // Round half away from zero, shift right by s.
    function automatic logic signed [ACC_BITS-1:0] shr_rnd(
        input logic signed [ACC_BITS-1:0] v, input int s);
        logic [ACC_BITS-1:0] a;
        begin
            a = v[ACC_BITS-1] ? ACC_BITS'(-v) : ACC_BITS'(v);
            a = (a + (ACC_BITS'(1) << (s - 1))) >> s;
            shr_rnd = v[ACC_BITS-1] ? -$signed(a) : $signed(a);
        end
    endfunction

endpackage

// ----- hw/rtl/pinhole_point_projection_top.sv -----
// Pinhole point projection.
// Channels: a point (point_x/y/z) transfers on a clock edge with start high
// and busy low. busy is always low: one point may enter every cycle.
// Results appear on pixel_u, pixel_v, depth_zero and clipped for one cycle,
// marked by done; the receiver cannot stall, so none is ever held.
// Steps, in order: R*p+T in a product and a sum stage, rounding, K*c in a
// product and a sum stage, the divider (one quotient bit per stage), output select.
// Throughput: one point per cycle, set by the fully pipelined divider.
// Configuration: cfg_we, cfg_index, cfg_data write one 63-bit register per
// edge; indexes beyond the list are dropped. Write only while idle.
// Reset: registers take identity rotation and intrinsics, zero translation;
// pipeline valid bits clear, so no result is produced until a point enters.
module pinhole_point_projection_top
    import ppp_pkg::*;
#(
    parameter int COEF_BITS  = 21,
    parameter int POINT_BITS = 24
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [POINT_BITS-1:0] point_x,
    input  logic signed [POINT_BITS-1:0] point_y,
    input  logic signed [POINT_BITS-1:0] point_z,
    input  logic                         cfg_we,
    input  logic [IDX_BITS-1:0]          cfg_index,
    input  logic [REG_BITS-1:0]          cfg_data,
    output logic                         done,
    output logic signed [OUT_BITS-1:0]   pixel_u,
    output logic signed [OUT_BITS-1:0]   pixel_v,
    output logic                         depth_zero,
    output logic                         clipped
);
    localparam int CW = 3 * COEF_BITS;
    // Camera point width: covers both the rotated point and the translation.
    localparam int C_BITS = ((POINT_BITS > COEF_BITS) ? POINT_BITS : COEF_BITS) + 4;
    localparam int NB = COEF_BITS + C_BITS + 1;
    localparam int DL = OUT_BITS + 4;   // divider stages + output

    logic [REG_BITS-1:0] regs_reg [NUM_REGS];

    // Hold configuration; reset to identity geometry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg[REG_ROT0]  <= 63'd524288;
            regs_reg[REG_ROT1]  <= 63'd1099511627776;
            regs_reg[REG_ROT2]  <= 63'd2305843009213693952;
            regs_reg[REG_TRANS] <= 63'd0;
            regs_reg[REG_INTR0] <= 63'd64;
            regs_reg[REG_INTR1] <= 63'd134217728;
            regs_reg[REG_INTR2] <= 63'd281474976710656;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROT0:  regs_reg[REG_ROT0]  <= cfg_data;
                REG_ROT1:  regs_reg[REG_ROT1]  <= cfg_data;
                REG_ROT2:  regs_reg[REG_ROT2]  <= cfg_data;
                REG_TRANS: regs_reg[REG_TRANS] <= cfg_data;
                REG_INTR0: regs_reg[REG_INTR0] <= cfg_data;
                REG_INTR1: regs_reg[REG_INTR1] <= cfg_data;
                REG_INTR2: regs_reg[REG_INTR2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Stage A: camera frame, R*p + T at 27 fraction bits.
    logic signed [POINT_BITS-1:0]   pvec [3];
    logic signed [ACC_BITS-1:0]     tbias [3];
    logic signed [ACC_BITS-1:0]     cacc [3];
    logic                           cvalid;

    assign pvec[0] = point_x;
    assign pvec[1] = point_y;
    assign pvec[2] = point_z;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            tbias[i] = ACC_BITS'($signed(regs_reg[REG_TRANS][i*COEF_BITS +: COEF_BITS]))
                       <<< ROT_FRAC;
    end

    ppp_matvec #(.CB(COEF_BITS), .VB(POINT_BITS)) u_rot (
        .clk(clk), .rst_n(rst_n), .in_valid(start),
        .row0(regs_reg[REG_ROT0][CW-1:0]), .row1(regs_reg[REG_ROT1][CW-1:0]),
        .row2(regs_reg[REG_ROT2][CW-1:0]),
        .vec(pvec), .bias(tbias), .out_valid(cvalid), .acc(cacc)
    );

    // Round camera point to 8 fraction bits.
    logic signed [C_BITS-1:0]   c_reg [3];
    logic                       cv_reg;
    logic signed [ACC_BITS-1:0] zero_b [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg <= 1'b0;
        else
            cv_reg <= cvalid;
    end
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            c_reg[i] <= C_BITS'(shr_rnd(cacc[i], ROT_FRAC));
    end
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            zero_b[i] = '0;
    end

    // Stage B: homogeneous point, K*c at 14 fraction bits.
    logic signed [ACC_BITS-1:0] hacc [3];
    logic                       hvalid;

    ppp_matvec #(.CB(COEF_BITS), .VB(C_BITS)) u_intr (
        .clk(clk), .rst_n(rst_n), .in_valid(cv_reg),
        .row0(regs_reg[REG_INTR0][CW-1:0]), .row1(regs_reg[REG_INTR1][CW-1:0]),
        .row2(regs_reg[REG_INTR2][CW-1:0]),
        .vec(c_reg), .bias(zero_b), .out_valid(hvalid), .acc(hacc)
    );

    // Stage C: two dividers in parallel, zero-depth path delayed alongside.
    logic                  dvalid;
    logic                  dvalid_v;
    logic [OUT_BITS-1:0]   qu, qv;
    logic                  cu, cv;
    logic signed [NB-1:0]  den_safe;

    assign den_safe = (hacc[2] == '0) ? NB'(1) : hacc[2][NB-1:0];

    ppp_divider #(.NB(NB)) u_div_u (
        .clk(clk), .rst_n(rst_n), .in_valid(hvalid),
        .num(hacc[0][NB-1:0]), .den(den_safe),
        .out_valid(dvalid), .quo(qu), .clip(cu)
    );
    ppp_divider #(.NB(NB)) u_div_v (
        .clk(clk), .rst_n(rst_n), .in_valid(hvalid),
        .num(hacc[1][NB-1:0]), .den(den_safe),
        .out_valid(dvalid_v), .quo(qv), .clip(cv)
    );

    logic [2*OUT_BITS+2:0] zd_reg [DL];
    logic [OUT_BITS:0]     zu, zv;

    assign zu = sat64(shr_rnd(hacc[0], HOMO_SH));
    assign zv = sat64(shr_rnd(hacc[1], HOMO_SH));

    // Advance the zero-depth result in step with the dividers.
    always_ff @(posedge clk)
    begin
        zd_reg[0] <= {hacc[2] == '0, zu, zv};
        for (int k = 1; k < DL; k++)
            zd_reg[k] <= zd_reg[k-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done <= 1'b0;
        else
            done <= dvalid & dvalid_v;
    end

    always_ff @(posedge clk)
    begin
        if (zd_reg[DL-1][2*OUT_BITS+2])
        begin
            pixel_u    <= zd_reg[DL-1][2*OUT_BITS:OUT_BITS+1];
            pixel_v    <= zd_reg[DL-1][OUT_BITS-1:0];
            depth_zero <= 1'b1;
            clipped    <= zd_reg[DL-1][2*OUT_BITS+1] | zd_reg[DL-1][OUT_BITS];
        end
        else
        begin
            pixel_u    <= qu;
            pixel_v    <= qv;
            depth_zero <= 1'b0;
            clipped    <= cu | cv;
        end
    end
endmodule

// ----- hw/rtl/ppp_matvec.sv -----
// Registered 3x3 matrix-vector product: one product stage, one sum stage.
module ppp_matvec
    import ppp_pkg::*;
#(
    parameter int CB = 21,
    parameter int VB = 32
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [3*CB-1:0]            row0,
    input  logic [3*CB-1:0]            row1,
    input  logic [3*CB-1:0]            row2,
    input  logic signed [VB-1:0]       vec [3],
    input  logic signed [ACC_BITS-1:0] bias [3],
    output logic                       out_valid,
    output logic signed [ACC_BITS-1:0] acc [3]
);
    logic signed [CB+VB-1:0]    prod_reg [3][3];
    logic signed [ACC_BITS-1:0] bias_reg [3];
    logic                       v1_reg;
    logic [3*CB-1:0]            rows [3];

    assign rows[0] = row0;
    assign rows[1] = row1;
    assign rows[2] = row2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v1_reg    <= in_valid;
            out_valid <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            bias_reg[i] <= bias[i];
            for (int j = 0; j < 3; j++)
                prod_reg[i][j] <= $signed(rows[i][j*CB +: CB]) * vec[j];
            acc[i] <= ACC_BITS'(prod_reg[i][0]) + ACC_BITS'(prod_reg[i][1])
                      + ACC_BITS'(prod_reg[i][2]) + bias_reg[i];
        end
    end
endmodule

// ----- hw/rtl/ppp_divider.sv -----
// Pipelined restoring divider: |num| / |den| with PIX_FRAC fraction bits,
// one quotient bit per stage, rounded half away from zero and saturated.
module ppp_divider
    import ppp_pkg::*;
#(
    parameter int NB = 50
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic signed [NB-1:0] num,
    input  logic signed [NB-1:0] den,
    output logic                 out_valid,
    output logic [OUT_BITS-1:0]  quo,
    output logic                 clip
);
    // Quotient bits: integer bits above limit only need a saturation flag.
    localparam int QB = OUT_BITS + 1;     // integer+fraction bits kept
    localparam int ST = QB + 1;           // plus round bit
    localparam int AB = NB + PIX_FRAC + 1;

    logic [AB-1:0] a_reg [ST+1];
    logic [AB-1:0] d_reg [ST+1];
    logic [ST-1:0] q_reg [ST+1];
    logic          n_reg [ST+1];
    logic          v_reg [ST+1];
    logic          big_reg [ST+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ST; k++)
                v_reg[k] <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= ST; k++)
                v_reg[k] <= v_reg[k-1];
            out_valid <= v_reg[ST];
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg[0]   <= AB'(num[NB-1] ? -num : num) << (PIX_FRAC + 1);
        d_reg[0]   <= AB'(den[NB-1] ? -den : den);
        n_reg[0]   <= num[NB-1] ^ den[NB-1];
        q_reg[0]   <= '0;
        big_reg[0] <= 1'b0;
        for (int k = 1; k <= ST; k++)
        begin
            logic [2*AB-1:0] dsh;
            dsh = {{AB{1'b0}}, d_reg[k-1]} << (ST - k);
            d_reg[k] <= d_reg[k-1];
            n_reg[k] <= n_reg[k-1];
            if (k == 1)
                // Anything needing bits above the kept ones is saturating.
                big_reg[k] <= ({{AB{1'b0}}, a_reg[k-1]} >= (dsh << 1));
            else
                big_reg[k] <= big_reg[k-1];
            if ({{AB{1'b0}}, a_reg[k-1]} >= dsh)
            begin
                a_reg[k] <= a_reg[k-1] - dsh[AB-1:0];
                q_reg[k] <= q_reg[k-1] | (ST'(1) << (ST - k));
            end
            else
            begin
                a_reg[k] <= a_reg[k-1];
                q_reg[k] <= q_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [ST:0] qr;
        logic [ST:0] lim;
        logic        neg;
        qr  = ({1'b0, q_reg[ST]} + (ST+1)'(1)) >> 1;
        neg = n_reg[ST] && (qr != '0);
        lim = (ST+1)'(2 ** (OUT_BITS - 1));
        clip <= 1'b0;
        if (neg)
        begin
            if (big_reg[ST] || qr > lim)
            begin
                quo  <= lim[OUT_BITS-1:0];
                clip <= 1'b1;
            end
            else
                quo <= OUT_BITS'(-qr);
        end
        else if (big_reg[ST] || qr > lim - 1)
        begin
            quo  <= OUT_BITS'(lim - 1);
            clip <= 1'b1;
        end
        else
            quo <= qr[OUT_BITS-1:0];
    end
endmodule
